// ===== hw/rtl/mpt_pkg.sv =====
package mpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W = 32;
    localparam int QUO_W = DATA_W + FRAC_BITS + 1;
    localparam int IN_TDATA_W = 136;
    localparam int OUT_TDATA_W = 96;

    localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_POINT = 1'b1
    } func_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [QUO_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > QUO_W'(S32_MAX) && v > 0)
        begin
            r = S32_MAX;
        end
        else if (v < $signed({{(QUO_W-DATA_W+1){1'b1}}, S32_MIN}))
        begin
            r = S32_MIN;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mpt_divider.sv =====
module mpt_divider
    import mpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] num_x,
    input  logic signed [DATA_W-1:0] num_y,
    input  logic signed [DATA_W-1:0] den,
    input  logic signed [DATA_W-1:0] pass_z,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] quo_x,
    output logic signed [DATA_W-1:0] quo_y,
    output logic signed [DATA_W-1:0] out_z,
    output logic                     div_err
);

    localparam int STEPS = QUO_W;
    localparam int UW = DATA_W + 1;

    typedef struct packed
    {
        logic            v;
        logic [QUO_W-1:0] qx;
        logic [QUO_W-1:0] qy;
        logic [UW-1:0]   rx;
        logic [UW-1:0]   ry;
        logic [UW-1:0]   d;
        logic            nx;
        logic            ny;
        logic            zx;
        logic            zy;
        logic            px;
        logic            py;
        logic            err;
        logic [DATA_W-1:0] z;
    } dstage_t;

    dstage_t stage_reg [STEPS+1];
    dstage_t stage_next [STEPS+1];

    function automatic logic [UW-1:0] absv(input logic signed [DATA_W-1:0] a);
        logic signed [UW-1:0] e;
        e = UW'(a);
        return (e < 0) ? UW'(-e) : UW'(e);
    endfunction

    always_comb
    begin
        stage_next[0].v = in_valid;
        stage_next[0].qx = QUO_W'(absv(num_x)) << FRAC_BITS;
        stage_next[0].qy = QUO_W'(absv(num_y)) << FRAC_BITS;
        stage_next[0].rx = '0;
        stage_next[0].ry = '0;
        stage_next[0].d = absv(den);
        stage_next[0].nx = num_x[DATA_W-1] ^ den[DATA_W-1];
        stage_next[0].ny = num_y[DATA_W-1] ^ den[DATA_W-1];
        stage_next[0].zx = (num_x == 0);
        stage_next[0].zy = (num_y == 0);
        stage_next[0].px = !num_x[DATA_W-1];
        stage_next[0].py = !num_y[DATA_W-1];
        stage_next[0].err = (den == 0);
        stage_next[0].z = pass_z;
        for (int i = 1; i <= STEPS; i++)
        begin
            logic [UW:0] tx;
            logic [UW:0] ty;
            stage_next[i] = stage_reg[i-1];
            tx = {stage_reg[i-1].rx, stage_reg[i-1].qx[QUO_W-1]};
            ty = {stage_reg[i-1].ry, stage_reg[i-1].qy[QUO_W-1]};
            stage_next[i].qx = {stage_reg[i-1].qx[QUO_W-2:0], 1'b0};
            stage_next[i].qy = {stage_reg[i-1].qy[QUO_W-2:0], 1'b0};
            if (tx >= {1'b0, stage_reg[i-1].d})
            begin
                tx = tx - {1'b0, stage_reg[i-1].d};
                stage_next[i].qx[0] = 1'b1;
            end
            if (ty >= {1'b0, stage_reg[i-1].d})
            begin
                ty = ty - {1'b0, stage_reg[i-1].d};
                stage_next[i].qy[0] = 1'b1;
            end
            stage_next[i].rx = tx[UW-1:0];
            stage_next[i].ry = ty[UW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                stage_reg[i].v <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] finish(
        input logic [QUO_W-1:0] q, input logic neg, input logic zero,
        input logic pos, input logic err);
        logic signed [QUO_W:0] s;
        logic signed [DATA_W-1:0] r;
        s = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (err)
        begin
            r = zero ? '0 : (pos ? S32_MAX : S32_MIN);
        end
        else
        begin
            r = sat32(s);
        end
        return r;
    endfunction

    assign out_valid = stage_reg[STEPS].v;
    assign quo_x = finish(stage_reg[STEPS].qx, stage_reg[STEPS].nx, stage_reg[STEPS].zx,
                          stage_reg[STEPS].px, stage_reg[STEPS].err);
    assign quo_y = finish(stage_reg[STEPS].qy, stage_reg[STEPS].ny, stage_reg[STEPS].zy,
                          stage_reg[STEPS].py, stage_reg[STEPS].err);
    assign out_z = stage_reg[STEPS].z;
    assign div_err = stage_reg[STEPS].err;

endmodule

// ===== hw/rtl/matrix_point_transform.sv =====
// Homogeneous 4x4 point transform with perspective divide, Q16.16.
// Slave channel s_axis: tdata carries func, row, col, entry_value, in_x,
// in_y, in_z. func 0 writes one matrix entry and gives no transfer out;
// func 1 transforms a point and gives one transfer on m_axis.
// Matrix writes take effect for every point accepted after them.
// Pipeline: 1 register stage for products, 1 for column sums, 1 for
// saturation, 1 divider input stage, then one stage per quotient bit (49)
// of the restoring divider for x and y, ending at m_axis tvalid.
// Throughput is one item per cycle while m_axis does not stall;
// the divider stages hold the depth.
// Reset clears all valid bits and loads the identity matrix.
// When m_axis stalls with a valid result the whole pipeline holds;
// s_axis tready is low only then, and no item is lost or repeated.
module matrix_point_transform
    import mpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // func, row, col, entry_value, in_x, in_y, in_z from bit 0 up
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_x, out_y, out_z from bit 0 up
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // divide_error
    output logic                   m_axis_tuser
);

    logic                     advance;
    logic                     func;
    logic [1:0]               row;
    logic [1:0]               col;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
    logic [DATA_W-1:0]        matrix_reg [16];
    logic                     p1_valid_reg;
    logic signed [2*DATA_W-1:0] prod_reg [12];
    logic                     p2_valid_reg;
    logic signed [QUO_W:0]    sum_reg [4];
    logic                     p3_valid_reg;
    logic signed [DATA_W-1:0] sx_reg;
    logic signed [DATA_W-1:0] sy_reg;
    logic signed [DATA_W-1:0] sz_reg;
    logic signed [DATA_W-1:0] w_reg;
    logic                     div_valid;
    logic signed [DATA_W-1:0] quo_x;
    logic signed [DATA_W-1:0] quo_y;
    logic signed [DATA_W-1:0] quo_z;
    logic                     div_err;

    assign func = s_axis_tdata[0];
    assign row = s_axis_tdata[2:1];
    assign col = s_axis_tdata[4:3];
    assign entry_value = s_axis_tdata[36:5];
    assign in_x = s_axis_tdata[68:37];
    assign in_y = s_axis_tdata[100:69];
    assign in_z = s_axis_tdata[132:101];

    assign advance = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                matrix_reg[i] <= (i % 5 == 0) ? ONE_FX : '0;
            end
        end
        else if (s_axis_tvalid && s_axis_tready && func == FUNC_WRITE)
        begin
            matrix_reg[{row, col}] <= entry_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= s_axis_tvalid && func == FUNC_POINT;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // products: index r*4+c for r in 0..2, c in 0..3; row 3 taken as is, but entry 15 is forced to one
    logic signed [DATA_W-1:0] row3_reg [4];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_reg[c]     <= in_x * $signed(matrix_reg[c]);
                prod_reg[4 + c] <= in_y * $signed(matrix_reg[4 + c]);
                prod_reg[8 + c] <= in_z * $signed(matrix_reg[8 + c]);
                row3_reg[c]     <= (c == 3) ? $signed(ONE_FX) : $signed(matrix_reg[12 + c]);
            end
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= (QUO_W+1)'(prod_reg[c] >>> FRAC_BITS)
                            + (QUO_W+1)'(prod_reg[4 + c] >>> FRAC_BITS)
                            + (QUO_W+1)'(prod_reg[8 + c] >>> FRAC_BITS)
                            + (QUO_W+1)'(row3_reg[c]);
            end
            sum_reg[3] <= (QUO_W+1)'(prod_reg[11] >>> FRAC_BITS) + (QUO_W+1)'(row3_reg[3]);
            sx_reg <= sat32(sum_reg[0]);
            sy_reg <= sat32(sum_reg[1]);
            sz_reg <= sat32(sum_reg[2]);
            w_reg  <= sat32(sum_reg[3]);
        end
    end

    mpt_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (p3_valid_reg),
        .num_x     (sx_reg),
        .num_y     (sy_reg),
        .den       (w_reg),
        .pass_z    (sz_reg),
        .out_valid (div_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .out_z     (quo_z),
        .div_err   (div_err)
    );

    assign m_axis_tvalid = div_valid;
    assign m_axis_tdata = {quo_z, quo_y, quo_x};
    assign m_axis_tuser = div_err;

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("accepted input while output stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && func == FUNC_POINT) |=> p1_valid_reg)
        else $error("point lost at entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && func == FUNC_WRITE) |=> !p1_valid_reg)
        else $error("write produced a result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser)
            |-> ((quo_x == S32_MAX || quo_x == S32_MIN || quo_x == 0)
                 && (quo_y == S32_MAX || quo_y == S32_MIN || quo_y == 0)))
        else $error("zero weight result not saturated");

endmodule

// ===== tb/matrix_point_transform_tb.sv =====
module matrix_point_transform_tb;
    import mpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 800;
    localparam int QUIET_TAIL = 80;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic signed [31:0] ONE = 32'sd65536;

    typedef struct {
        func_t             func;
        logic [1:0]        row;
        logic [1:0]        col;
        logic signed [31:0] entry;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } item_t;

    typedef struct {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic              err;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    item_t pending_items[$];
    point_t expected_points[$];
    item_t cur_item;
    logic signed [31:0] model_matrix[16];
    logic taken = 1'b0;
    int errors = 0;
    int src_idle = 0;
    int snk_idle = 0;
    int sent_count = 0;
    int pause_at = 0;
    bit paused_once = 0;
    int stall_cycles = 0;

    matrix_point_transform u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint scaled_product(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint column_total(input int c, input item_t it);
        longint s;
        s = scaled_product(it.px, model_matrix[c]);
        s += scaled_product(it.py, model_matrix[4 + c]);
        s += scaled_product(it.pz, model_matrix[8 + c]);
        s += longint'(model_matrix[12 + c]);
        return clamp32(s);
    endfunction

    function automatic longint perspective_div(input longint num, input longint w);
        if (w == 0)
        begin
            return (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
        end
        return clamp32((num * 65536) / w);
    endfunction

    task automatic apply_item(input item_t it);
        point_t r;
        longint sx, sy, sz, w;
        if (it.func == FUNC_WRITE)
        begin
            model_matrix[{it.row, it.col}] = it.entry;
        end
        else
        begin
            sx = column_total(0, it);
            sy = column_total(1, it);
            sz = column_total(2, it);
            w = clamp32(scaled_product(model_matrix[11], it.pz) + 65536);
            r.ox = 32'(perspective_div(sx, w));
            r.oy = 32'(perspective_div(sy, w));
            r.oz = 32'(sz);
            r.err = (w == 0);
            expected_points.push_back(r);
        end
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_entry();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $urandom_range(0, 1) ? ONE : 32'sh0;
            default: return $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
        endcase
    endfunction

    task automatic queue_write(input int r, input int c, input logic signed [31:0] v);
        item_t it;
        it.func = FUNC_WRITE;
        it.row = r[1:0];
        it.col = c[1:0];
        it.entry = v;
        it.px = $urandom();
        it.py = $urandom();
        it.pz = $urandom();
        pending_items.push_back(it);
    endtask

    task automatic queue_point(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] z);
        item_t it;
        it.func = FUNC_POINT;
        it.row = 2'($urandom());
        it.col = 2'($urandom());
        it.entry = $urandom();
        it.px = x;
        it.py = y;
        it.pz = z;
        pending_items.push_back(it);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            apply_item(cur_item);
            taken <= 1'b1;
        end
        else
        begin
            taken <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || taken))
        begin
            if (!paused_once && sent_count == pause_at && expected_points.size() != 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else if (src_idle > 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_idle <= src_idle - 1;
            end
            else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_idle <= $urandom_range(0, 15);
            end
            else if (pending_items.size() != 0)
            begin
                if (sent_count == pause_at)
                begin
                    paused_once <= 1;
                end
                cur_item = pending_items.pop_front();
                s_axis_tdata <= {3'b0, cur_item.pz, cur_item.py, cur_item.px,
                                 cur_item.entry, cur_item.col, cur_item.row, cur_item.func};
                s_axis_tvalid <= 1'b1;
                sent_count <= sent_count + 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (snk_idle > 0)
        begin
            m_axis_tready <= 1'b0;
            snk_idle <= snk_idle - 1;
        end
        else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            snk_idle <= $urandom_range(0, 15);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected transfer: x=%h y=%h z=%h err=%b", m_axis_tdata[31:0],
                       m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser);
                errors++;
            end
            else
            begin
                e = expected_points.pop_front();
                if (m_axis_tdata[31:0] !== e.ox)
                begin
                    $error("out_x expected %h actual %h", e.ox, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.oy)
                begin
                    $error("out_y expected %h actual %h", e.oy, m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== e.oz)
                begin
                    $error("out_z expected %h actual %h", e.oz, m_axis_tdata[95:64]);
                    errors++;
                end
                if (m_axis_tuser !== e.err)
                begin
                    $error("divide_error expected %b actual %b", e.err, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            model_matrix[i] = (i % 5 == 0) ? ONE : 32'sh0;
        end

        queue_point(ONE, 2 * ONE, 3 * ONE);
        queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        queue_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_point(0, 0, 0);
        queue_write(3, 3, 32'sh7FFF_FFFF);
        queue_write(0, 1, 32'sh8000_0000);
        queue_write(3, 0, 32'sh7FFF_FFFF);
        queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, ONE);
        queue_write(2, 3, ONE);
        queue_point(ONE, -ONE, -ONE);
        queue_point(-ONE, ONE, -ONE);
        queue_write(3, 0, 0);
        queue_write(0, 1, 0);
        queue_point(0, 0, -ONE);
        queue_point(5 * ONE, 7 * ONE, ONE);
        queue_write(2, 3, 32'sh0000_8000);
        queue_point(ONE, ONE, 32'sh8000_0000);
        queue_point(3 * ONE, -3 * ONE, -ONE);
        queue_write(2, 3, 0);
        queue_write(1, 2, 32'sh7FFF_FFFF);
        queue_point(ONE, 32'sh7FFF_FFFF, ONE);
        queue_write(1, 2, 0);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    queue_write($urandom_range(0, 3), $urandom_range(0, 3), rand_entry());
                end
                3:
                begin
                    queue_write(2, 3, ONE);
                    queue_point(rand_coord(), rand_coord(), -ONE);
                end
                4:
                begin
                    queue_write(2, 3, $urandom_range(0, 1) ? 32'sh0 : rand_entry());
                end
                default:
                begin
                    queue_point(rand_coord(), rand_coord(), rand_coord());
                end
            endcase
        end
        pause_at = pending_items.size() / 2;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !s_axis_tvalid && expected_points.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_points.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== matrix_point_transform.f =====
hw/rtl/mpt_pkg.sv
hw/rtl/mpt_divider.sv
hw/rtl/matrix_point_transform.sv
tb/matrix_point_transform_tb.sv
